FILE: rtl/iis_pkg.sv
// shared types and constants of the integer image scaler
package iis_pkg;

	localparam int FACTOR_W   = 4;
	localparam int DIM_W      = 13;
	localparam int ROW_W      = 12;
	localparam int MAX_HEIGHT = 4096;
	localparam int HUE_W      = 15;
	localparam int CH_W       = 13;
	localparam int COORD_W    = 15;
	localparam int HUE_SUM_W  = 21;
	localparam int CH_SUM_W   = 19;
	localparam int AREA_W     = 7;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	// floor(v / k) == (v * RECIP[k]) >> RECIP_SHIFT for v below 2**14 and k up to 8
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 17;

	localparam logic [1:0] REG_DIRECTION = 2'd0;
	localparam logic [1:0] REG_FACTOR    = 2'd1;
	localparam logic [1:0] REG_WIDTH     = 2'd2;
	localparam logic [1:0] REG_HEIGHT    = 2'd3;

	typedef struct packed {
		logic [HUE_W-1:0] in_hue;
		logic [CH_W-1:0]  in_sat;
		logic [CH_W-1:0]  in_lum;
		logic [CH_W-1:0]  in_alpha;
	} pix_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic [HUE_W-1:0]   out_hue;
		logic [CH_W-1:0]    out_sat;
		logic [CH_W-1:0]    out_lum;
		logic [CH_W-1:0]    out_alpha;
		logic               last_of_run;
	} res_t;

	typedef struct packed {
		logic [HUE_SUM_W-1:0] hue;
		logic [CH_SUM_W-1:0]  sat;
		logic [CH_SUM_W-1:0]  lum;
		logic [CH_SUM_W-1:0]  alpha;
	} sums_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_UP,
		ST_CHECK,
		ST_READ,
		ST_UPDATE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	function automatic logic [RECIP_W-1:0] recip(input logic [FACTOR_W-1:0] k);
		logic [RECIP_W-1:0] r;
		case (k)
			4'd1:    r = 18'd131072;
			4'd2:    r = 18'd65536;
			4'd3:    r = 18'd43691;
			4'd4:    r = 18'd32768;
			4'd5:    r = 18'd26215;
			4'd6:    r = 18'd21846;
			4'd7:    r = 18'd18725;
			4'd8:    r = 18'd16384;
			default: r = 18'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/iis_box_div.sv
// restoring divider: four channel sums divided by the block area, one bit per cycle
module iis_box_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [iis_pkg::AREA_W-1:0]  area,
	input  iis_pkg::sums_t              sums,
	output logic                        done,
	output iis_pkg::sums_t              quot
);
	import iis_pkg::*;

	localparam int NCH = 4;
	localparam int CW  = $clog2(HUE_SUM_W + 1);

	logic [HUE_SUM_W-1:0] dvd_q [NCH];
	logic [AREA_W-1:0]    rem_q [NCH];
	logic [AREA_W-1:0]    area_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [AREA_W:0]      trial [NCH];
	logic                 qbit  [NCH];
	logic [AREA_W-1:0]    rem_d [NCH];

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			trial[c] = {rem_q[c], dvd_q[c][HUE_SUM_W-1]};
			qbit[c]  = (trial[c] >= {1'b0, area_q});
			if (qbit[c]) begin
				rem_d[c] = AREA_W'(trial[c] - {1'b0, area_q});
			end else begin
				rem_d[c] = trial[c][AREA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(HUE_SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			area_q   <= area;
			dvd_q[0] <= sums.hue;
			dvd_q[1] <= HUE_SUM_W'(sums.sat);
			dvd_q[2] <= HUE_SUM_W'(sums.lum);
			dvd_q[3] <= HUE_SUM_W'(sums.alpha);
			for (int c = 0; c < NCH; c++) begin
				rem_q[c] <= '0;
			end
		end else if (busy_q) begin
			for (int c = 0; c < NCH; c++) begin
				rem_q[c] <= rem_d[c];
				dvd_q[c] <= {dvd_q[c][HUE_SUM_W-2:0], qbit[c]};
			end
		end
	end

	assign done       = done_q;
	assign quot.hue   = dvd_q[0];
	assign quot.sat   = CH_SUM_W'(dvd_q[1]);
	assign quot.lum   = CH_SUM_W'(dvd_q[2]);
	assign quot.alpha = CH_SUM_W'(dvd_q[3]);

endmodule

FILE: rtl/integer_image_scaler_unit.sv
// integer image scaler top level: counters, accumulator memory, control and config port
//
// pixels enter in raster order on pix_valid/pix_ready, results leave on res_valid/res_ready.
// one input transaction is worked on at a time; a result sits in an output register, so the
// next pixel is taken while the last result of the previous one still waits.
// per pixel: factor 1 passes the pixel through; upscale by k emits k*k results, one for each
// replicated position; downscale only accumulates most pixels, and a pixel that closes a block
// also runs the 21-step area divider before its result is emitted.
// the column sums live in one memory of MAX_WIDTH/2 entries with a registered read,
// read, added to and written back per downscaled pixel inside the full blocks.
// after reset the block clears all MAX_WIDTH/2 entries of that memory, one entry a cycle
// (2048 by default); pix_ready stays low meanwhile, config writes are taken as ever.
// a stalled receiver holds the output register, and the block when it has another result.
// config (apb, pready always high): 0x0 direction, 0x4 factor, 0x8 width, 0xc height.
module integer_image_scaler_unit #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_FACTOR = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  iis_pkg::pix_t               pix,
	output logic                        res_valid,
	input  logic                        res_ready,
	output iis_pkg::res_t               res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [iis_pkg::ADDR_W-1:0]  paddr,
	input  logic [iis_pkg::DATA_W-1:0]  pwdata,
	output logic [iis_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import iis_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = CW + 1;
	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int IW    = $clog2(DEPTH);
	localparam int PW    = $clog2(MAX_FACTOR);

	// config registers
	logic                dir_q;
	logic [FACTOR_W-1:0] factor_q;
	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;

	logic                cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= 1'b0;
			factor_q <= FACTOR_W'(1);
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DIRECTION: dir_q    <= pwdata[0];
				REG_FACTOR:    factor_q <= pwdata[FACTOR_W-1:0];
				REG_WIDTH:     width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT:    height_q <= pwdata[DIM_W-1:0];
				default:       dir_q    <= dir_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DIRECTION: prdata = DATA_W'(dir_q);
			REG_FACTOR:    prdata = DATA_W'(factor_q);
			REG_WIDTH:     prdata = DATA_W'(width_q);
			REG_HEIGHT:    prdata = DATA_W'(height_q);
			default:       prdata = '0;
		endcase
	end

	// effective factor and size
	logic [FACTOR_W-1:0] k_eff;
	logic [WW-1:0]       w_eff;
	logic [DIM_W-1:0]    h_eff;

	always_comb begin
		if (factor_q == '0) begin
			k_eff = FACTOR_W'(1);
		end else if (int'(factor_q) > MAX_FACTOR) begin
			k_eff = FACTOR_W'(MAX_FACTOR);
		end else begin
			k_eff = factor_q;
		end
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	state_t state_q, state_d;

	logic pix_acc;
	assign pix_acc = pix_valid && pix_ready;

	// position counters, advanced as each pixel is taken
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [PW-1:0]    bcp_q;
	logic [PW-1:0]    brp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			bcp_q <= '0;
			brp_q <= '0;
		end else if (pix_acc) begin
			if ({1'b0, col_q} + WW'(1) >= w_eff) begin
				col_q <= '0;
				bcp_q <= '0;
				if ({1'b0, row_q} + DIM_W'(1) >= h_eff) begin
					row_q <= '0;
					brp_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					if (FACTOR_W'(brp_q) + FACTOR_W'(1) >= k_eff) begin
						brp_q <= '0;
					end else begin
						brp_q <= brp_q + PW'(1);
					end
				end
			end else begin
				col_q <= col_q + CW'(1);
				if (FACTOR_W'(bcp_q) + FACTOR_W'(1) >= k_eff) begin
					bcp_q <= '0;
				end else begin
					bcp_q <= bcp_q + PW'(1);
				end
			end
		end
	end

	// transaction held for the whole run
	pix_t                pix_s1;
	logic [CW-1:0]       x_s1;
	logic [ROW_W-1:0]    y_s1;
	logic [FACTOR_W-1:0] k_s1;
	logic [WW-1:0]       w_s1;
	logic [DIM_W-1:0]    h_s1;
	logic                dir_s1;
	logic [PW-1:0]       bcp_s1;
	logic [PW-1:0]       brp_s1;
	logic [RECIP_W-1:0]  recip_s1;

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_s1   <= pix;
			x_s1     <= col_q;
			y_s1     <= row_q;
			k_s1     <= k_eff;
			w_s1     <= w_eff;
			h_s1     <= h_eff;
			dir_s1   <= dir_q;
			bcp_s1   <= bcp_q;
			brp_s1   <= brp_q;
			recip_s1 <= recip(k_eff);
		end
	end

	// quotients by k through reciprocal products, and upscale base coordinates
	logic [CW+RECIP_W-1:0]    prod_x;
	logic [ROW_W+RECIP_W-1:0] prod_y;
	logic [WW+RECIP_W-1:0]    prod_w;
	logic [DIM_W+RECIP_W-1:0] prod_h;
	logic [CW+FACTOR_W-1:0]   base_x;
	logic [ROW_W+FACTOR_W-1:0] base_y;
	logic [2*FACTOR_W-1:0]    area_full;

	assign prod_x    = (CW+RECIP_W)'(x_s1) * (CW+RECIP_W)'(recip_s1);
	assign prod_y    = (ROW_W+RECIP_W)'(y_s1) * (ROW_W+RECIP_W)'(recip_s1);
	assign prod_w    = (WW+RECIP_W)'(w_s1) * (WW+RECIP_W)'(recip_s1);
	assign prod_h    = (DIM_W+RECIP_W)'(h_s1) * (DIM_W+RECIP_W)'(recip_s1);
	assign base_x    = (CW+FACTOR_W)'(x_s1) * (CW+FACTOR_W)'(k_s1);
	assign base_y    = (ROW_W+FACTOR_W)'(y_s1) * (ROW_W+FACTOR_W)'(k_s1);
	assign area_full = {{FACTOR_W{1'b0}}, k_s1} * {{FACTOR_W{1'b0}}, k_s1};

	logic [CW-1:0]      qx_s2;
	logic [ROW_W-1:0]   qy_s2;
	logic [WW-1:0]      qw_s2;
	logic [DIM_W-1:0]   qh_s2;
	logic [COORD_W-1:0] bx_s2;
	logic [COORD_W-1:0] by_s2;
	logic [AREA_W-1:0]  area_s2;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			qx_s2   <= prod_x[RECIP_SHIFT +: CW];
			qy_s2   <= prod_y[RECIP_SHIFT +: ROW_W];
			qw_s2   <= prod_w[RECIP_SHIFT +: WW];
			qh_s2   <= prod_h[RECIP_SHIFT +: DIM_W];
			bx_s2   <= COORD_W'(base_x);
			by_s2   <= COORD_W'(base_y);
			area_s2 <= AREA_W'(area_full);
		end
	end

	logic in_full;
	logic closes_block;
	logic k_is_one;
	assign in_full      = (WW'(qx_s2) < qw_s2) && (DIM_W'(qy_s2) < qh_s2);
	assign closes_block = (FACTOR_W'(brp_s1) == k_s1 - FACTOR_W'(1)) &&
	                      (FACTOR_W'(bcp_s1) == k_s1 - FACTOR_W'(1));
	assign k_is_one     = (k_s1 == FACTOR_W'(1));

	// replication counters
	logic [PW-1:0] lx_q;
	logic [PW-1:0] ly_q;
	logic          lx_end;
	logic          ly_end;
	assign lx_end = (FACTOR_W'(lx_q) == k_s1 - FACTOR_W'(1));
	assign ly_end = (FACTOR_W'(ly_q) == k_s1 - FACTOR_W'(1));

	// output register
	res_t res_q;
	logic res_valid_q;
	logic res_free;
	logic res_load;
	res_t res_d;
	assign res_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// accumulator memory
	logic [IW-1:0] clr_q;
	logic [IW-1:0] mem_addr;
	logic          mem_we;
	sums_t         mem_wdata;
	sums_t         rd_q;
	sums_t         sums_mem [DEPTH];

	logic          div_start;
	logic          div_done;
	sums_t         quot;

	sums_t new_sums;
	always_comb begin
		if (brp_s1 == '0) begin
			new_sums.hue   = HUE_SUM_W'(pix_s1.in_hue);
			new_sums.sat   = CH_SUM_W'(pix_s1.in_sat);
			new_sums.lum   = CH_SUM_W'(pix_s1.in_lum);
			new_sums.alpha = CH_SUM_W'(pix_s1.in_alpha);
		end else begin
			new_sums.hue   = rd_q.hue + HUE_SUM_W'(pix_s1.in_hue);
			new_sums.sat   = rd_q.sat + CH_SUM_W'(pix_s1.in_sat);
			new_sums.lum   = rd_q.lum + CH_SUM_W'(pix_s1.in_lum);
			new_sums.alpha = rd_q.alpha + CH_SUM_W'(pix_s1.in_alpha);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sums_mem[mem_addr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= sums_mem[mem_addr];
	end

	iis_box_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.area   (area_s2),
		.sums   (new_sums),
		.done   (div_done),
		.quot   (quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == IW'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (pix_valid) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (k_is_one) state_d = ST_EMIT;
				else if (!dir_s1) state_d = ST_UP;
				else state_d = ST_CHECK;
			end
			ST_UP: begin
				if (res_free && lx_end && ly_end) state_d = ST_IDLE;
			end
			ST_CHECK: begin
				state_d = in_full ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = closes_block ? ST_DIVIDE : ST_IDLE;
			end
			ST_DIVIDE: begin
				if (div_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (res_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the control
	always_comb begin
		pix_ready = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = qx_s2[IW-1:0];
		mem_wdata = new_sums;
		div_start = 1'b0;
		res_load  = 1'b0;
		res_d     = res_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				pix_ready = 1'b1;
			end
			ST_UP: begin
				res_load          = res_free;
				res_d.out_x       = bx_s2 + COORD_W'(lx_q);
				res_d.out_y       = by_s2 + COORD_W'(ly_q);
				res_d.out_hue     = pix_s1.in_hue;
				res_d.out_sat     = pix_s1.in_sat;
				res_d.out_lum     = pix_s1.in_lum;
				res_d.out_alpha   = pix_s1.in_alpha;
				res_d.last_of_run = lx_end && ly_end;
			end
			ST_UPDATE: begin
				mem_we    = 1'b1;
				div_start = closes_block;
			end
			ST_EMIT: begin
				res_load          = res_free;
				res_d.last_of_run = 1'b1;
				if (k_is_one) begin
					res_d.out_x     = COORD_W'(x_s1);
					res_d.out_y     = COORD_W'(y_s1);
					res_d.out_hue   = pix_s1.in_hue;
					res_d.out_sat   = pix_s1.in_sat;
					res_d.out_lum   = pix_s1.in_lum;
					res_d.out_alpha = pix_s1.in_alpha;
				end else begin
					res_d.out_x     = COORD_W'(qx_s2);
					res_d.out_y     = COORD_W'(qy_s2);
					res_d.out_hue   = HUE_W'(quot.hue);
					res_d.out_sat   = CH_W'(quot.sat);
					res_d.out_lum   = CH_W'(quot.lum);
					res_d.out_alpha = CH_W'(quot.alpha);
				end
			end
			default: pix_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
			lx_q        <= '0;
			ly_q        <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == ST_MUL) begin
				lx_q <= '0;
				ly_q <= '0;
			end else if (state_q == ST_UP && res_free) begin
				if (lx_end) begin
					lx_q <= '0;
					ly_q <= ly_q + PW'(1);
				end else begin
					lx_q <= lx_q + PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

endmodule

FILE: rtl/iis_checker.sv
// port-level checks of the integer image scaler, bound to the top level
module iis_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          pix_valid,
	input logic          pix_ready,
	input logic          res_valid,
	input logic          res_ready,
	input iis_pkg::res_t res,
	input logic          pready
);
	import iis_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res))
		else $error("result changed while stalled");

	// one pixel at a time: busy right after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> !pix_ready)
		else $error("pixel taken while previous one is in work");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind integer_image_scaler_unit iis_checker u_iis_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res),
	.pready    (pready)
);

FILE: tb/sv/tb_integer_image_scaler_unit.sv
// testbench of the integer image scaler: predicted results checked against the block's output
`timescale 1ns / 100ps

module tb_integer_image_scaler_unit;
	import iis_pkg::*;

	localparam int MAX_W      = 4096;
	localparam int MAX_K      = 8;
	localparam int SUM_DEPTH  = MAX_W / 2;
	localparam int IDLE_WAIT  = 80;

	logic                clk;
	logic                arst_n;
	logic                pix_valid;
	logic                pix_ready;
	pix_t                pix;
	logic                res_valid;
	logic                res_ready;
	res_t                res;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	integer_image_scaler_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [0:0]  cfg_dir;
	logic [3:0]  cfg_factor;
	logic [12:0] cfg_width;
	logic [12:0] cfg_height;
	int unsigned col_pos, row_pos, col_phase, row_phase;
	logic [20:0] hue_acc [SUM_DEPTH];
	logic [18:0] sat_acc [SUM_DEPTH];
	logic [18:0] lum_acc [SUM_DEPTH];
	logic [18:0] alpha_acc [SUM_DEPTH];

	res_t        expected_q[$];
	int          mismatches;
	int          results_seen;
	int          pixels_sent;
	int          stall_mode;
	bit          stall_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("timeout");
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int unsigned eff_k();
		if (cfg_factor == 0) return 1;
		if (cfg_factor > MAX_K) return MAX_K;
		return cfg_factor;
	endfunction

	function automatic int unsigned eff_dim(logic [12:0] v);
		if (v == 0) return 1;
		if (v > 4096) return 4096;
		return v;
	endfunction

	function automatic res_t make_res(int unsigned x, int unsigned y, logic [14:0] h,
			logic [12:0] s, logic [12:0] l, logic [12:0] a, logic last);
		res_t r;
		r.out_x       = x[14:0];
		r.out_y       = y[14:0];
		r.out_hue     = h;
		r.out_sat     = s;
		r.out_lum     = l;
		r.out_alpha   = a;
		r.last_of_run = last;
		return r;
	endfunction

	task automatic predict_scaled(input pix_t p);
		int unsigned k, w, h, x, y, fw, fh, cb, area;
		k = eff_k();
		w = eff_dim(cfg_width);
		h = eff_dim(cfg_height);
		x = col_pos;
		y = row_pos;
		if (k == 1) begin
			expected_q.push_back(make_res(x, y, p.in_hue, p.in_sat, p.in_lum, p.in_alpha, 1'b1));
		end else if (cfg_dir == 1'b0) begin
			for (int unsigned ly = 0; ly < k; ly++)
				for (int unsigned lx = 0; lx < k; lx++)
					expected_q.push_back(make_res(x * k + lx, y * k + ly, p.in_hue, p.in_sat,
						p.in_lum, p.in_alpha, (ly == k - 1) && (lx == k - 1)));
		end else begin
			fw = (w / k) * k;
			fh = (h / k) * k;
			if (x < fw && y < fh) begin
				cb = (x / k) % SUM_DEPTH;
				if (row_phase == 0) begin
					hue_acc[cb]   = p.in_hue;
					sat_acc[cb]   = p.in_sat;
					lum_acc[cb]   = p.in_lum;
					alpha_acc[cb] = p.in_alpha;
				end else begin
					hue_acc[cb]   = hue_acc[cb] + p.in_hue;
					sat_acc[cb]   = sat_acc[cb] + p.in_sat;
					lum_acc[cb]   = lum_acc[cb] + p.in_lum;
					alpha_acc[cb] = alpha_acc[cb] + p.in_alpha;
				end
				if (row_phase == k - 1 && col_phase == k - 1) begin
					area = k * k;
					expected_q.push_back(make_res(x / k, y / k, 15'(hue_acc[cb] / area),
						13'(sat_acc[cb] / area), 13'(lum_acc[cb] / area),
						13'(alpha_acc[cb] / area), 1'b1));
				end
			end
		end
		// raster position advance
		if (col_pos + 1 >= w) begin
			col_pos   = 0;
			col_phase = 0;
			row_phase = (row_phase + 1 >= k) ? 0 : row_phase + 1;
			if (row_pos + 1 >= h) begin
				row_pos   = 0;
				row_phase = 0;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
			col_phase = (col_phase + 1 >= k) ? 0 : col_phase + 1;
		end
	endtask

	// valid stays high into the next transaction; gaps and drains drop it
	task automatic send_pixel(input pix_t p);
		pix       <= p;
		pix_valid <= 1'b1;
		do @(posedge clk); while (!pix_ready);
		predict_scaled(p);
		pixels_sent++;
		@(negedge clk);
	endtask

	// bursty sender: random gap before some pixels
	task automatic send_random(input pix_t p);
		if ($urandom_range(0, 3) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		send_pixel(p);
	endtask

	function automatic pix_t rand_pixel();
		pix_t p;
		case ($urandom_range(0, 5))
			0: p = '0;
			1: begin
				p.in_hue   = 15'd23040;
				p.in_sat   = 13'd4096;
				p.in_lum   = 13'd4096;
				p.in_alpha = 13'd4096;
			end
			2: p = pix_t'({$urandom, $urandom});
			default: begin
				p.in_hue   = 15'($urandom_range(0, 23040));
				p.in_sat   = 13'($urandom_range(0, 4096));
				p.in_lum   = 13'($urandom_range(0, 4096));
				p.in_alpha = 13'($urandom_range(0, 4096));
			end
		endcase
		return p;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_DIRECTION: cfg_dir    = value[0];
			REG_FACTOR:    cfg_factor = value[3:0];
			REG_WIDTH:     cfg_width  = value[12:0];
			default:       cfg_height = value[12:0];
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (IDLE_WAIT) @(negedge clk);
	endtask

	task automatic configure(input logic dir, input logic [3:0] k, input logic [12:0] w,
			input logic [12:0] h);
		drain();
		write_reg(REG_DIRECTION, 32'(dir));
		write_reg(REG_FACTOR, 32'(k));
		write_reg(REG_WIDTH, 32'(w));
		write_reg(REG_HEIGHT, 32'(h));
	endtask

	task automatic test_pass_through();
		pix_t p;
		configure(1'b0, 4'd1, 13'd3, 13'd2);
		p = '0;
		send_pixel(p);
		p = '1;
		send_pixel(p);
		p.in_hue = 15'd23040; p.in_sat = 13'd4096; p.in_lum = 13'd4096; p.in_alpha = 13'd4096;
		send_pixel(p);
		// zero factor and zero sizes behave as one
		configure(1'b1, 4'd0, 13'd0, 13'd0);
		send_pixel(rand_pixel());
		send_pixel(rand_pixel());
	endtask

	task automatic test_upscale();
		configure(1'b0, 4'd2, 13'd3, 13'd2);
		repeat (4) send_pixel(rand_pixel());
		// oversized factor clamps to eight
		configure(1'b0, 4'd15, 13'd2, 13'd1);
		repeat (2) send_pixel(rand_pixel());
	endtask

	task automatic test_downscale();
		pix_t p;
		p.in_hue = 15'd23040; p.in_sat = 13'd4096; p.in_lum = 13'd4096; p.in_alpha = 13'd4096;
		configure(1'b1, 4'd2, 13'd5, 13'd4);
		repeat (10) send_pixel(p);
		repeat (10) send_pixel(rand_pixel());
		// image narrower than factor: all pixels ignored
		configure(1'b1, 4'd3, 13'd2, 13'd5);
		repeat (4) send_pixel(rand_pixel());
	endtask

	task automatic test_oversized_size();
		configure(1'b1, 4'd8, 13'd8191, 13'd8191);
		repeat (4) send_pixel(rand_pixel());
		configure(1'b0, 4'd1, 13'd8191, 13'd8191);
		repeat (2) send_pixel(rand_pixel());
	endtask

	task automatic test_mid_frame_change();
		configure(1'b1, 4'd3, 13'd7, 13'd6);
		repeat (11) send_pixel(rand_pixel());
		// shrink the frame under a running position
		configure(1'b1, 4'd2, 13'd3, 13'd2);
		repeat (12) send_pixel(rand_pixel());
	endtask

	task automatic test_random();
		int unsigned k, w, h, n;
		for (int ph = 0; ph < 10; ph++) begin
			k = (ph % 3 == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
			w = (ph == 9) ? $urandom : $urandom_range(1, 10);
			h = (ph == 9) ? $urandom : $urandom_range(1, 8);
			configure(1'(ph % 2), 4'(k), 13'(w), 13'(h));
			stall_mode = ph % 3;
			n = (ph % 2 == 1) ? 30 : 12;
			repeat (n) send_random(rand_pixel());
		end
		stall_mode = 0;
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: res_ready <= 1'b1;
				1: res_ready <= ($urandom_range(0, 3) != 0);
				default: begin
					if ($urandom_range(0, 7) == 0) stall_on = !stall_on;
					res_ready <= !stall_on;
				end
			endcase
		end
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", res);
			end else begin
				e = expected_q.pop_front();
				if (res.out_x !== e.out_x || res.out_y !== e.out_y ||
						res.out_hue !== e.out_hue || res.out_sat !== e.out_sat ||
						res.out_lum !== e.out_lum || res.out_alpha !== e.out_alpha ||
						res.last_of_run !== e.last_of_run) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", e, res);
				end
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		pix_valid   = 1'b0;
		pix         = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		cfg_dir     = 1'b0;
		cfg_factor  = 4'd1;
		cfg_width   = 13'd1;
		cfg_height  = 13'd1;
		col_pos     = 0;
		row_pos     = 0;
		col_phase   = 0;
		row_phase   = 0;
		mismatches  = 0;
		results_seen = 0;
		pixels_sent = 0;
		stall_mode  = 1;
		for (int i = 0; i < SUM_DEPTH; i++) begin
			hue_acc[i] = '0; sat_acc[i] = '0; lum_acc[i] = '0; alpha_acc[i] = '0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_pass_through();
		test_upscale();
		test_downscale();
		test_oversized_size();
		test_mid_frame_change();
		test_random();
		drain();
		$display("%0d pixels sent, %0d results checked, over pass-through, upscale and",
			pixels_sent, results_seen);
		$display("downscale settings including clamped factors and sizes");
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
